### hdl/isq_pkg.sv
// Types and constants shared by the indication send queue modules.
package isq_pkg;

  localparam int HandleW  = 16;
  localparam int LengthW  = 3;
  localparam int PayloadW = 40;
  localparam int OutcomeW = 3;
  localparam int WaitW    = 5;

  localparam logic [LengthW-1:0] MaxLength = 3'd5;

  // Request kinds
  localparam logic [1:0] KIND_SUBMIT  = 2'd0;
  localparam logic [1:0] KIND_CONFIRM = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;
  localparam logic [1:0] KIND_RESET   = 2'd3;

  // Result outcomes
  localparam logic [OutcomeW-1:0] OUT_SENT    = 3'd0;
  localparam logic [OutcomeW-1:0] OUT_QUEUED  = 3'd1;
  localparam logic [OutcomeW-1:0] OUT_DROPPED = 3'd2;
  localparam logic [OutcomeW-1:0] OUT_REFUSED = 3'd3;
  localparam logic [OutcomeW-1:0] OUT_NOTHING = 3'd4;
  localparam logic [OutcomeW-1:0] OUT_CLEARED = 3'd5;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HandleW-1:0]  msg_handle;
    logic [LengthW-1:0]  msg_length;
    logic [PayloadW-1:0] msg_payload;
    logic                link_accepts;
  } isq_req_t;

  typedef struct packed {
    logic                send_valid;
    logic [HandleW-1:0]  send_handle;
    logic [LengthW-1:0]  send_length;
    logic [PayloadW-1:0] send_payload;
    logic [OutcomeW-1:0] outcome;
    logic [WaitW-1:0]    waiting_count;
    logic                busy_res;
  } isq_res_t;

  typedef struct packed {
    logic [HandleW-1:0]  handle;
    logic [LengthW-1:0]  length;
    logic [PayloadW-1:0] payload;
  } isq_entry_t;

endpackage

### hdl/isq_store.sv
// Entry memory: one write port, registered read of the head entry with write bypass.
module isq_store import isq_pkg::*; #(
  parameter int Depth = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(Depth)-1:0]   wr_addr,
  input  isq_entry_t                 wr_data,
  input  logic [$clog2(Depth)-1:0]   rd_addr,
  output isq_entry_t                 head
);

  isq_entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // same-edge write to the head slot must show up next cycle
    if (wr_en && (wr_addr == rd_addr)) begin
      head <= wr_data;
    end else begin
      head <= mem[rd_addr];
    end
  end

endmodule

### hdl/isq_ctrl.sv
// Queue pointers, flags and the per-request decision logic.
module isq_ctrl import isq_pkg::*; #(
  parameter int Depth = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  isq_req_t                   req,
  input  isq_entry_t                 head,
  output isq_res_t                   res,
  output logic                       wr_en,
  output logic [$clog2(Depth)-1:0]   wr_addr,
  output isq_entry_t                 wr_data,
  output logic [$clog2(Depth)-1:0]   rd_addr
);

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  logic [IdxW-1:0] write_index, write_index_next;
  logic [IdxW-1:0] read_index, read_index_next;
  logic            store_full, store_full_next;
  logic [CntW-1:0] entry_count, entry_count_next;
  logic            in_flight, in_flight_next;

  logic [IdxW-1:0] write_inc, read_inc;
  isq_entry_t      msg;
  logic            push;
  logic [CntW+WaitW-1:0] count_ext;

  assign write_inc = (write_index == LastIdx) ? '0 : write_index + 1'b1;
  assign read_inc  = (read_index == LastIdx) ? '0 : read_index + 1'b1;

  always_comb begin
    msg.handle  = req.msg_handle;
    msg.length  = (req.msg_length > MaxLength) ? MaxLength : req.msg_length;
    msg.payload = req.msg_payload;
  end

  always_comb begin
    write_index_next = write_index;
    read_index_next  = read_index;
    store_full_next  = store_full;
    entry_count_next = entry_count;
    in_flight_next   = in_flight;
    push             = 1'b0;
    res              = '0;
    res.outcome      = OUT_NOTHING;

    unique case (req.kind)
      KIND_SUBMIT: begin
        if (in_flight) begin
          if (store_full) begin
            res.outcome = OUT_DROPPED;
          end else begin
            push             = 1'b1;
            write_index_next = write_inc;
            store_full_next  = (write_inc == read_index);
            entry_count_next = entry_count + 1'b1;
            res.outcome      = OUT_QUEUED;
          end
        end else if (req.link_accepts) begin
          in_flight_next   = 1'b1;
          res.send_valid   = 1'b1;
          res.send_handle  = msg.handle;
          res.send_length  = msg.length;
          res.send_payload = msg.payload;
          res.outcome      = OUT_SENT;
        end else begin
          res.outcome = OUT_REFUSED;
        end
      end
      KIND_CONFIRM: begin
        in_flight_next = 1'b0;
      end
      KIND_TICK: begin
        if ((entry_count != '0) && !in_flight) begin
          if (req.link_accepts) begin
            store_full_next  = 1'b0;
            read_index_next  = read_inc;
            in_flight_next   = 1'b1;
            entry_count_next = entry_count - 1'b1;
            res.send_valid   = 1'b1;
            res.send_handle  = head.handle;
            res.send_length  = head.length;
            res.send_payload = head.payload;
            res.outcome      = OUT_SENT;
          end else begin
            res.outcome = OUT_REFUSED;
          end
        end
      end
      KIND_RESET: begin
        write_index_next = '0;
        read_index_next  = '0;
        store_full_next  = 1'b0;
        entry_count_next = '0;
        in_flight_next   = 1'b0;
        res.outcome      = OUT_CLEARED;
      end
      default: begin
      end
    endcase

    count_ext         = {{WaitW{1'b0}}, entry_count_next};
    res.waiting_count = count_ext[WaitW-1:0];
    res.busy_res      = in_flight_next;
  end

  assign wr_en   = go && push;
  assign wr_addr = write_index;
  assign wr_data = msg;
  // keep the head read aimed at the pointer as it will stand after this edge
  assign rd_addr = go ? read_index_next : read_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      store_full  <= 1'b0;
      entry_count <= '0;
      in_flight   <= 1'b0;
    end else if (go) begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      store_full  <= store_full_next;
      entry_count <= entry_count_next;
      in_flight   <= in_flight_next;
    end
  end

endmodule

### hdl/indication_send_queue_unit.sv
// Indication send queue: flow-controlled sender for acknowledged messages.
// Request channel: req_valid / req_stall / req (kind, handle, length, payload,
// link_accepts). Result channel: res_valid / res_stall / res; exactly one
// result per request, in request order.
// A request is registered on acceptance, decided against the queue state while
// it sits in the request register and written to the result register once that
// register can take it. One request per cycle is sustained while results are not stalled.
// The queue decision path is a single pass of compare/increment logic; the
// head entry is prefetched from the entry memory every cycle, with a bypass
// when a submit writes the slot the head pointer names.
// A stalled result holds its register; the request register then holds too
// and req_stall rises, so nothing is lost or repeated.
// Reset (rst, synchronous) empties the queue, clears in-flight and drops both
// pipeline registers; memory contents are not cleared and need no sweep.
module indication_send_queue_unit import isq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  isq_req_t req,
  output logic     res_valid,
  input  logic     res_stall,
  output isq_res_t res
);

  localparam int IdxW = $clog2(QUEUE_DEPTH);

  logic       stage_valid;
  isq_req_t   stage_req;
  logic       advance;
  isq_res_t   ctrl_res;
  isq_entry_t head;
  logic       wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;
  isq_entry_t wr_data;

  assign advance   = stage_valid && (!res_valid || !res_stall);
  assign req_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!req_stall) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      stage_req <= req;
    end
  end

  isq_ctrl #(
    .Depth (QUEUE_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .go      (advance),
    .req     (stage_req),
    .head    (head),
    .res     (ctrl_res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr)
  );

  isq_store #(
    .Depth (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .head    (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= ctrl_res;
    end
  end

endmodule

### bench/testbench.sv
// Self-checking bench for the indication send queue: predictor, stimulus and result checks.
module testbench;
  import isq_pkg::*;

  localparam int Depth         = 16;
  localparam int WatchdogLimit = 3000;
  localparam int LongHold      = 80;
  localparam int MaxReports    = 10;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  isq_req_t req       = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  isq_res_t res;

  indication_send_queue_unit #(
    .QUEUE_DEPTH(Depth)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted queue state
  isq_entry_t slots[Depth];
  int         wr_ptr      = 0;
  int         rd_ptr      = 0;
  int         waiting     = 0;
  bit         slots_full  = 1'b0;
  bit         in_flight_q = 1'b0;

  isq_res_t   expected_results[$];
  int         failures    = 0;
  int         idle_cycles = 0;

  // Idle control shared between the stimulus and the result side
  bit         tx_idle_on  = 1'b1;
  bit         rx_idle_on  = 1'b1;
  bit         hold_req    = 1'b0;
  int         hold_left   = 0;
  int         rx_burst    = 0;

  function automatic int step_ptr(int p);
    return (p == Depth - 1) ? 0 : p + 1;
  endfunction

  function automatic isq_res_t predict_queue_step(isq_req_t r);
    isq_res_t   o;
    isq_entry_t m;
    isq_entry_t head;
    o         = '0;
    m.handle  = r.msg_handle;
    m.length  = (r.msg_length > MaxLength) ? MaxLength : r.msg_length;
    m.payload = r.msg_payload;
    case (r.kind)
      KIND_SUBMIT: begin
        if (in_flight_q) begin
          if (slots_full) begin
            o.outcome = OUT_DROPPED;
          end else begin
            slots[wr_ptr] = m;
            wr_ptr = step_ptr(wr_ptr);
            if (wr_ptr == rd_ptr) slots_full = 1'b1;
            waiting++;
            o.outcome = OUT_QUEUED;
          end
        end else if (r.link_accepts) begin
          in_flight_q    = 1'b1;
          o.send_valid   = 1'b1;
          o.send_handle  = m.handle;
          o.send_length  = m.length;
          o.send_payload = m.payload;
          o.outcome      = OUT_SENT;
        end else begin
          // link refused a direct send: the message is lost
          o.outcome = OUT_REFUSED;
        end
      end
      KIND_CONFIRM: begin
        in_flight_q = 1'b0;
        o.outcome   = OUT_NOTHING;
      end
      KIND_TICK: begin
        if (waiting != 0 && !in_flight_q) begin
          head = slots[rd_ptr];
          if (r.link_accepts) begin
            slots_full     = 1'b0;
            rd_ptr         = step_ptr(rd_ptr);
            in_flight_q    = 1'b1;
            waiting--;
            o.send_valid   = 1'b1;
            o.send_handle  = head.handle;
            o.send_length  = head.length;
            o.send_payload = head.payload;
            o.outcome      = OUT_SENT;
          end else begin
            o.outcome = OUT_REFUSED;
          end
        end else begin
          o.outcome = OUT_NOTHING;
        end
      end
      default: begin
        wr_ptr      = 0;
        rd_ptr      = 0;
        slots_full  = 1'b0;
        waiting     = 0;
        in_flight_q = 1'b0;
        o.outcome   = OUT_CLEARED;
      end
    endcase
    o.waiting_count = WaitW'(waiting);
    o.busy_res      = in_flight_q;
    return o;
  endfunction

  // Requests are predicted on acceptance; results are checked in order.
  always @(posedge clk) begin : track_results
    isq_res_t want;
    bit       bad;
    if (!rst) begin
      if (req_valid && !req_stall) expected_results.push_back(predict_queue_step(req));
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= MaxReports)
            $display("unexpected result: outcome=%0d handle=%h", res.outcome, res.send_handle);
        end else begin
          want = expected_results.pop_front();
          bad  = (res.send_valid !== want.send_valid) ||
                 (res.send_handle !== want.send_handle) ||
                 (res.send_length !== want.send_length) ||
                 (res.send_payload !== want.send_payload) ||
                 (res.outcome !== want.outcome) ||
                 (res.waiting_count !== want.waiting_count) ||
                 (res.busy_res !== want.busy_res);
          if (bad) begin
            failures++;
            if (failures <= MaxReports) begin
              $display("mismatch exp: sv=%0d h=%h len=%0d pl=%h out=%0d wait=%0d busy=%0d",
                       want.send_valid, want.send_handle, want.send_length, want.send_payload,
                       want.outcome, want.waiting_count, want.busy_res);
              $display("         got: sv=%0d h=%h len=%0d pl=%h out=%0d wait=%0d busy=%0d",
                       res.send_valid, res.send_handle, res.send_length, res.send_payload,
                       res.outcome, res.waiting_count, res.busy_res);
            end
          end
        end
      end
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result-side stall: random bursts, plus one long hold on request
  always @(posedge clk) begin : result_backpressure
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LongHold - 1;
      res_stall <= 1'b1;
    end else if (rx_burst > 0) begin
      rx_burst--;
      res_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_burst = $urandom_range(1, 12) - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  function automatic isq_req_t make_req(logic [1:0] kind, logic [HandleW-1:0] handle,
                                        logic [LengthW-1:0] length,
                                        logic [PayloadW-1:0] payload, logic accepts);
    isq_req_t r;
    r.kind         = kind;
    r.msg_handle   = handle;
    r.msg_length   = length;
    r.msg_payload  = payload;
    r.link_accepts = accepts;
    return r;
  endfunction

  // Random fields; fill_heavy favors submits, otherwise confirm/tick drain traffic
  function automatic isq_req_t random_req(bit fill_heavy);
    isq_req_t    r;
    logic [63:0] wide;
    int          pick;
    wide           = {$urandom, $urandom};
    pick           = $urandom_range(0, 99);
    r.msg_handle   = HandleW'($urandom);
    r.msg_length   = LengthW'($urandom_range(0, 7));
    r.msg_payload  = wide[PayloadW-1:0];
    r.link_accepts = ($urandom_range(0, 9) != 0);
    if (fill_heavy)
      r.kind = (pick < 60) ? KIND_SUBMIT : (pick < 78) ? KIND_TICK :
               (pick < 97) ? KIND_CONFIRM : KIND_RESET;
    else
      r.kind = (pick < 20) ? KIND_SUBMIT : (pick < 56) ? KIND_TICK :
               (pick < 97) ? KIND_CONFIRM : KIND_RESET;
    return r;
  endfunction

  // Offer one request and hold it until accepted
  task automatic issue_request(isq_req_t r);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_directed_cases();
    issue_request(make_req(KIND_TICK, 16'h1234, 3'd2, 40'h1, 1'b1));  // tick on empty queue
    issue_request(make_req(KIND_CONFIRM, 16'hFFFF, 3'd7, '1, 1'b0));
    issue_request(make_req(KIND_SUBMIT, 16'hFFFF, 3'd5, '1, 1'b0));   // refused, lost
    issue_request(make_req(KIND_SUBMIT, 16'hFFFF, 3'd5, '1, 1'b1));
    issue_request(make_req(KIND_SUBMIT, 16'h0000, 3'd7, '0, 1'b1));   // length saturates
    issue_request(make_req(KIND_SUBMIT, 16'hA5A5, 3'd6, 40'h5A_A55A_A55A, 1'b0));
    issue_request(make_req(KIND_SUBMIT, 16'h0001, 3'd0, 40'h01_0203_0405, 1'b1));
    issue_request(make_req(KIND_TICK, 16'h0, 3'd0, 40'h0, 1'b1));     // busy: nothing
    issue_request(make_req(KIND_CONFIRM, 16'h0, 3'd0, 40'h0, 1'b1));
    issue_request(make_req(KIND_TICK, 16'h0, 3'd0, 40'h0, 1'b0));     // head stays
    issue_request(make_req(KIND_TICK, 16'h0, 3'd0, 40'h0, 1'b1));
    issue_request(make_req(KIND_TICK, 16'h0, 3'd0, 40'h0, 1'b1));
    issue_request(make_req(KIND_CONFIRM, 16'h0, 3'd0, 40'h0, 1'b0));
    issue_request(make_req(KIND_TICK, 16'h0, 3'd0, 40'h0, 1'b1));
    issue_request(make_req(KIND_RESET, 16'hFFFF, 3'd7, '1, 1'b1));    // entries still waiting
    issue_request(make_req(KIND_TICK, 16'h0, 3'd0, 40'h0, 1'b1));
    issue_request(make_req(KIND_SUBMIT, 16'h8000, 3'd1, 40'h80_0000_0000, 1'b1));
  endtask

  // Fill past full, then drain with pointer wrap
  task automatic test_full_store();
    isq_req_t r;
    issue_request(make_req(KIND_RESET, 16'h0, 3'd0, 40'h0, 1'b0));
    issue_request(make_req(KIND_SUBMIT, 16'h0, 3'd3, 40'h0, 1'b1));
    for (int i = 0; i < Depth + 2; i++) begin
      r      = random_req(1'b1);
      r.kind = KIND_SUBMIT;
      issue_request(r);
    end
    for (int i = 0; i < 20; i++) begin
      issue_request(make_req(KIND_CONFIRM, 16'h0, 3'd0, 40'h0, 1'b1));
      r      = random_req(1'b0);
      r.kind = KIND_TICK;
      issue_request(r);
      if (i % 3 == 0) begin
        r      = random_req(1'b1);
        r.kind = KIND_SUBMIT;
        issue_request(r);
      end
    end
  endtask

  // Long result stall with the sender still offering: fills the pipeline
  task automatic test_output_hold();
    tx_idle_on = 1'b0;
    hold_req   = 1'b1;
    for (int i = 0; i < 40; i++) issue_request(random_req(i < 20));
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count - 60) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (i % 70 == 69) wait_for_results();
      issue_request(random_req(((i / 40) % 2) == 0));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_store();
    test_output_hold();
    test_random_traffic(300);
    wait_for_results();
    repeat (8) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/isq_pkg.sv
hdl/isq_store.sv
hdl/isq_ctrl.sv
hdl/indication_send_queue_unit.sv
bench/testbench.sv
